// File: hw/rtl/ncp_pkg.sv
package ncp_pkg;

    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } ncp_ctrl_t;

endpackage

// File: hw/rtl/unit_normal_cross_product.sv
// Channel   Direction  Beat contents
// s_        in         tdata: a_x, a_y, a_z, b_x, b_y, b_z (IN_WIDTH bits each)
// m_        out        tdata: n_x, n_y, n_z (OUT_FRAC_BITS+2 bits each); tuser: degenerate
//
// One beat is accepted per cycle unless both output entries are full; there is one
// square-root stage per root bit and one divider stage per quotient bit.
// Reset is synchronous and active low and clears every valid bit.
// A two-entry output register absorbs a stall; the pipeline freezes only when both are full.
module unit_normal_cross_product
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH      = 15,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, zero fill
    input  logic [((6*IN_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // n_x, n_y, n_z, zero fill
    output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic [0:0] m_tuser
);

    localparam int W   = IN_WIDTH;
    localparam int CW  = 2 * IN_WIDTH + 1;
    localparam int OW  = OUT_FRAC_BITS + 2;
    localparam int NW  = NUM_AXES * OW;
    localparam int MDW = ((3 * OW + 7) / 8) * 8;

    logic                   en;
    ncp_ctrl_t              x_ctrl, q_ctrl, r_ctrl, d_ctrl;
    logic [NUM_AXES*CW-1:0] x_c, q_c, r_c;
    logic [4*W-1:0]         q_s;
    logic [2*W-1:0]         r_len;
    logic [NW-1:0]          d_n;

    logic            m_valid_reg;
    logic [NW-1:0]   m_n_reg;
    logic            m_deg_reg;
    logic            skid_valid_reg;
    logic [NW-1:0]   skid_n_reg;
    logic            skid_deg_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ncp_cross #(.IN_WIDTH(IN_WIDTH)) u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .a_x      (s_tdata[0*W +: W]),
        .a_y      (s_tdata[1*W +: W]),
        .a_z      (s_tdata[2*W +: W]),
        .b_x      (s_tdata[3*W +: W]),
        .b_y      (s_tdata[4*W +: W]),
        .b_z      (s_tdata[5*W +: W]),
        .out_ctrl (x_ctrl),
        .out_c    (x_c)
    );

    ncp_square #(.IN_WIDTH(IN_WIDTH)) u_square (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctrl  (x_ctrl),
        .in_c     (x_c),
        .out_ctrl (q_ctrl),
        .out_c    (q_c),
        .out_s    (q_s)
    );

    ncp_isqrt #(.IN_WIDTH(IN_WIDTH)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctrl  (q_ctrl),
        .in_c     (q_c),
        .in_s     (q_s),
        .out_ctrl (r_ctrl),
        .out_c    (r_c),
        .out_len  (r_len)
    );

    ncp_div #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctrl  (r_ctrl),
        .in_c     (r_c),
        .in_len   (r_len),
        .out_ctrl (d_ctrl),
        .out_n    (d_n)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_n_reg        <= skid_n_reg;
                m_deg_reg      <= skid_deg_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (d_ctrl.valid) begin
            if (!m_valid_reg || m_tready) begin
                m_n_reg     <= d_n;
                m_deg_reg   <= d_ctrl.degenerate;
                m_valid_reg <= 1'b1;
            end else begin
                skid_n_reg     <= d_n;
                skid_deg_reg   <= d_ctrl.degenerate;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'(m_n_reg);
    assign m_tuser  = m_deg_reg;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without a pending output beat");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid entry filled while output was free");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_deg_reg) |-> (m_n_reg == '0))
        else $error("degenerate beat carries a nonzero normal");

    a_normal_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_deg_reg) |-> (m_n_reg != '0))
        else $error("regular beat carries an all-zero normal");

endmodule

// File: hw/rtl/ncp_cross.sv
module ncp_cross
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH = 15
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [IN_WIDTH-1:0]  a_x,
    input  logic signed [IN_WIDTH-1:0]  a_y,
    input  logic signed [IN_WIDTH-1:0]  a_z,
    input  logic signed [IN_WIDTH-1:0]  b_x,
    input  logic signed [IN_WIDTH-1:0]  b_y,
    input  logic signed [IN_WIDTH-1:0]  b_z,
    output ncp_ctrl_t                   out_ctrl,
    output logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] out_c
);

    localparam int PW = 2 * IN_WIDTH;
    localparam int CW = 2 * IN_WIDTH + 1;

    logic signed [PW-1:0] p_reg [6];
    logic signed [PW-1:0] p_next [6];
    logic                 v1_reg;
    logic signed [CW-1:0] c_next [NUM_AXES];
    logic [NUM_AXES*CW-1:0] c_reg;
    ncp_ctrl_t            ctrl_reg;
    ncp_ctrl_t            ctrl_next;

    always_comb begin
        p_next[0] = PW'(a_y * b_z);
        p_next[1] = PW'(a_z * b_y);
        p_next[2] = PW'(a_z * b_x);
        p_next[3] = PW'(a_x * b_z);
        p_next[4] = PW'(a_x * b_y);
        p_next[5] = PW'(a_y * b_x);
    end

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            c_next[j] = CW'(p_reg[2*j]) - CW'(p_reg[2*j+1]);
        end
        ctrl_next.valid      = v1_reg;
        ctrl_next.degenerate = (c_next[0] == '0) && (c_next[1] == '0) && (c_next[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            ctrl_reg <= '0;
        end else if (en) begin
            v1_reg   <= in_valid;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                p_reg[i] <= p_next[i];
            end
            c_reg <= {c_next[2], c_next[1], c_next[0]};
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_c    = c_reg;

endmodule

// File: hw/rtl/ncp_square.sv
module ncp_square
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  ncp_ctrl_t                          in_ctrl,
    input  logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] in_c,
    output ncp_ctrl_t                          out_ctrl,
    output logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] out_c,
    output logic [4*IN_WIDTH-1:0]              out_s
);

    localparam int W  = IN_WIDTH;
    localparam int CW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int SW = 4 * W;

    logic signed [CW-1:0] c_lane [NUM_AXES];
    logic [MW-1:0]        m_lane [NUM_AXES];
    logic [MW-1:0]        hh_next [NUM_AXES];
    logic [MW-1:0]        hl_next [NUM_AXES];
    logic [MW-1:0]        ll_next [NUM_AXES];
    logic [MW-1:0]        hh_reg [NUM_AXES];
    logic [MW-1:0]        hl_reg [NUM_AXES];
    logic [MW-1:0]        ll_reg [NUM_AXES];
    logic [NUM_AXES*CW-1:0] c1_reg;
    logic [NUM_AXES*CW-1:0] c2_reg;
    ncp_ctrl_t            ctrl1_reg;
    ncp_ctrl_t            ctrl2_reg;
    logic [SW-1:0]        s_next;
    logic [SW-1:0]        s_reg;

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            c_lane[j]  = in_c[j*CW +: CW];
            m_lane[j]  = c_lane[j][CW-1] ? MW'(-c_lane[j]) : MW'(c_lane[j]);
            hh_next[j] = MW'(m_lane[j][MW-1:W] * m_lane[j][MW-1:W]);
            hl_next[j] = MW'(m_lane[j][MW-1:W] * m_lane[j][W-1:0]);
            ll_next[j] = MW'(m_lane[j][W-1:0] * m_lane[j][W-1:0]);
        end
    end

    always_comb begin
        s_next = '0;
        for (int j = 0; j < NUM_AXES; j++) begin
            s_next = s_next + (SW'(hh_reg[j]) << MW) + (SW'(hl_reg[j]) << (W + 1))
                   + SW'(ll_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else if (en) begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                hh_reg[j] <= hh_next[j];
                hl_reg[j] <= hl_next[j];
                ll_reg[j] <= ll_next[j];
            end
            c1_reg <= in_c;
            c2_reg <= c1_reg;
            s_reg  <= s_next;
        end
    end

    assign out_ctrl = ctrl2_reg;
    assign out_c    = c2_reg;
    assign out_s    = s_reg;

endmodule

// File: hw/rtl/ncp_isqrt.sv
module ncp_isqrt
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  ncp_ctrl_t                          in_ctrl,
    input  logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] in_c,
    input  logic [4*IN_WIDTH-1:0]              in_s,
    output ncp_ctrl_t                          out_ctrl,
    output logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] out_c,
    output logic [2*IN_WIDTH-1:0]              out_len
);

    localparam int LW = 2 * IN_WIDTH;
    localparam int SW = 4 * IN_WIDTH;
    localparam int RW = LW + 3;
    localparam int DW = NUM_AXES * (2 * IN_WIDTH + 1);

    logic [RW-1:0] rem_reg  [LW];
    logic [LW-1:0] root_reg [LW];
    logic [SW-1:0] s_reg    [LW];
    logic [DW-1:0] c_reg    [LW];
    ncp_ctrl_t     ctrl_reg [LW];

    for (genvar k = 0; k < LW; k++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [LW-1:0] root_in;
        logic [SW-1:0] s_in;
        logic [DW-1:0] c_in;
        ncp_ctrl_t     ctrl_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = in_s;
            assign c_in    = in_c;
            assign ctrl_in = in_ctrl;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign c_in    = c_reg[k-1];
            assign ctrl_in = ctrl_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-3:0], s_in[SW-1:SW-2]};
        assign trial  = RW'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[k] <= '0;
            end else if (en) begin
                ctrl_reg[k] <= ctrl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_in[LW-2:0], ge};
                s_reg[k]    <= s_in << 2;
                c_reg[k]    <= c_in;
            end
        end
    end

    assign out_ctrl = ctrl_reg[LW-1];
    assign out_c    = c_reg[LW-1];
    assign out_len  = root_reg[LW-1];

endmodule

// File: hw/rtl/ncp_div.sv
module ncp_div
    import ncp_pkg::*;
#(
    parameter int IN_WIDTH      = 15,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  ncp_ctrl_t                          in_ctrl,
    input  logic [NUM_AXES*(2*IN_WIDTH+1)-1:0] in_c,
    input  logic [2*IN_WIDTH-1:0]              in_len,
    output ncp_ctrl_t                          out_ctrl,
    output logic [NUM_AXES*(OUT_FRAC_BITS+2)-1:0] out_n
);

    localparam int LW = 2 * IN_WIDTH;
    localparam int CW = 2 * IN_WIDTH + 1;
    localparam int QW = OUT_FRAC_BITS + 1;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int NS = OUT_FRAC_BITS + 1;

    logic [LW:0]          rem_reg  [NS][NUM_AXES];
    logic [QW-1:0]        q_reg    [NS][NUM_AXES];
    logic [NUM_AXES-1:0]  neg_reg  [NS];
    logic [LW-1:0]        len_reg  [NS];
    ncp_ctrl_t            ctrl_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [LW-1:0]       len_in;
        ncp_ctrl_t           ctrl_in;
        logic [NUM_AXES-1:0] neg_in;

        if (k == 0) begin : g_first
            assign len_in  = in_len;
            assign ctrl_in = in_ctrl;
            for (genvar j = 0; j < NUM_AXES; j++) begin : g_sign
                assign neg_in[j] = in_c[j*CW + CW - 1];
            end
        end else begin : g_rest
            assign len_in  = len_reg[k-1];
            assign ctrl_in = ctrl_reg[k-1];
            assign neg_in  = neg_reg[k-1];
        end

        for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
            logic [LW:0]          rem_in;
            logic [QW-1:0]        q_in;
            logic                 ge;

            if (k == 0) begin : g_first
                logic signed [CW-1:0] c_lane;

                assign c_lane = in_c[j*CW +: CW];
                assign rem_in = c_lane[CW-1] ? (LW+1)'(-c_lane) : (LW+1)'(c_lane);
                assign q_in   = '0;
            end else begin : g_rest
                assign rem_in = {rem_reg[k-1][j][LW-1:0], 1'b0};
                assign q_in   = q_reg[k-1][j];
            end

            assign ge = rem_in >= {1'b0, len_in};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][j] <= ge ? rem_in - {1'b0, len_in} : rem_in;
                    q_reg[k][j]   <= {q_in[QW-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[k] <= '0;
            end else if (en) begin
                ctrl_reg[k] <= ctrl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[k] <= neg_in;
                len_reg[k] <= len_in;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            if (ctrl_reg[NS-1].degenerate) begin
                out_n[j*OW +: OW] = '0;
            end else if (neg_reg[NS-1][j]) begin
                out_n[j*OW +: OW] = -OW'(q_reg[NS-1][j]);
            end else begin
                out_n[j*OW +: OW] = OW'(q_reg[NS-1][j]);
            end
        end
    end

    assign out_ctrl = ctrl_reg[NS-1];

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

class normal_scoreboard;
    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } normal_t;

    normal_t pending_normals[$];
    int      error_count;

    function logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function logic [15:0] scale(longint c, logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        m = (c < 0) ? -c : c;
        q = (m << 14) / len;
        if (c < 0) q = -q;
        return q[15:0];
    endfunction

    function void note_input(logic signed [14:0] ax, logic signed [14:0] ay,
                             logic signed [14:0] az, logic signed [14:0] bx,
                             logic signed [14:0] by, logic signed [14:0] bz);
        longint cx;
        longint cy;
        longint cz;
        logic [63:0] sq;
        logic [63:0] len;
        normal_t n;
        cx = longint'(ay) * bz - longint'(az) * by;
        cy = longint'(az) * bx - longint'(ax) * bz;
        cz = longint'(ax) * by - longint'(ay) * bx;
        if (cx == 0 && cy == 0 && cz == 0) begin
            n = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end else begin
            sq = cx * cx + cy * cy + cz * cz;
            len = root_floor(sq);
            if (len == 0) len = 1;
            n = '{scale(cx, len), scale(cy, len), scale(cz, len), 1'b0};
        end
        pending_normals.push_back(n);
    endfunction

    function void check_result(logic [47:0] data, logic degen);
        normal_t e;
        if (pending_normals.size() == 0) begin
            $error("unexpected result beat %h", data);
            error_count++;
            return;
        end
        e = pending_normals.pop_front();
        if (data[15:0] !== e.nx) begin
            $error("n_x expected %0d actual %0d", e.nx, $signed(data[15:0]));
            error_count++;
        end
        if (data[31:16] !== e.ny) begin
            $error("n_y expected %0d actual %0d", e.ny, $signed(data[31:16]));
            error_count++;
        end
        if (data[47:32] !== e.nz) begin
            $error("n_z expected %0d actual %0d", e.nz, $signed(data[47:32]));
            error_count++;
        end
        if (degen !== e.degen) begin
            $error("degenerate expected %0d actual %0d", e.degen, degen);
            error_count++;
        end
    endfunction
endclass

module tb_top;
    import ncp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    normal_scoreboard normals;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    unit_normal_cross_product uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) normals.check_result(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles > 4000) begin
                $display("** unit_normal_cross_product: FAILED **");
                $finish;
            end
        end
    end

    // The six fields fill the low 90 bits of tdata; the top six bits stay zero.
    task automatic send_vectors(logic [14:0] ax, logic [14:0] ay, logic [14:0] az,
                                logic [14:0] bx, logic [14:0] by, logic [14:0] bz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, bz, by, bx, az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        normals.note_input(ax, ay, az, bx, by, bz);
    endtask

    function automatic logic [14:0] rand_comp(int mode);
        case (mode)
            0: return 15'h4000;
            1: return 15'h3fff;
            2: return 15'($urandom_range(15) - 8);
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [14:0] a[3];
        logic [14:0] b[3];
        int k;
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_comp($urandom_range(9));
            b[i] = rand_comp($urandom_range(9));
        end
        k = $urandom_range(9);
        // Parallel or zero vectors exercise the degenerate path.
        if (k == 0) b = a;
        if (k == 1) for (int i = 0; i < 3; i++) b[i] = -a[i];
        if (k == 2) for (int i = 0; i < 3; i++) b[i] = 15'($signed(a[i]) >>> 1);
        send_vectors(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    initial begin
        normals = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_vectors(1, 0, 0, 0, 1, 0);
        send_vectors(0, 1, 0, 1, 0, 0);
        send_vectors(0, 0, 1, 1, 0, 0);
        send_vectors(0, 0, 0, 0, 0, 0);
        send_vectors(3, 4, 5, 6, 8, 10);
        send_vectors(15'h4000, 15'h4000, 15'h4000, 15'h3fff, 15'h3fff, 15'h3fff);
        send_vectors(15'h4000, 15'h3fff, 15'h4000, 15'h3fff, 15'h4000, 15'h3fff);
        send_vectors(15'h4000, 0, 0, 0, 15'h4000, 0);
        send_vectors(15'h3fff, 15'h4000, 0, 15'h4000, 15'h3fff, 0);
        send_vectors(15'h7fff, 15'h7fff, 0, 1, 0, 0);
        send_vectors(15'h5555, 15'h2aaa, 15'h7fff, 15'h2aaa, 15'h5555, 15'h0001);
        send_vectors(15'h4000, 15'h4000, 0, 15'h4000, 15'h4000, 0);
        send_vectors(1, 2, 3, 15'h4000, 15'h3fff, 15'h7ffe);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 6) : 0;
            recv_stall_pct = (ph == 2) ? 51 : (ph == 3 ? 6 : 0);
            repeat (475) send_random();
        end
        s_tvalid <= 0;
        while (normals.pending_normals.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (normals.error_count == 0 && normals.pending_normals.size() == 0) begin
            $display("** unit_normal_cross_product: PASSED **");
        end else begin
            $display("** unit_normal_cross_product: FAILED **");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/ncp_pkg.sv
hw/rtl/ncp_cross.sv
hw/rtl/ncp_square.sv
hw/rtl/ncp_isqrt.sv
hw/rtl/ncp_div.sv
hw/rtl/unit_normal_cross_product.sv
bench/tb_top.sv
